@@ design/joint_drive_safety_mode_fsm_top_macros.svh @@
// Assertion macros shared by the safety mode block. All of them sample on clk.
`ifndef JOINT_DRIVE_SAFETY_MODE_FSM_TOP_MACROS_SVH
`define JOINT_DRIVE_SAFETY_MODE_FSM_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every rising edge, but not while rst_n is low.
`define JDSM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, including the edges during reset.
`define JDSM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define JDSM_ASSERT(lbl, prop, msg)
`define JDSM_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ design/jdsm_pkg.sv @@
package jdsm_pkg;

    localparam int TIME_W = 32;
    localparam int CFG_W  = 32;
    localparam int CMP_W  = (TIME_W > CFG_W) ? TIME_W : CFG_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_RAMP_TIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMU_OPTIONAL      = 2'd2;

    typedef enum logic [2:0] {
        MODE_WAIT    = 3'd0,
        MODE_READY   = 3'd1,
        MODE_LOWGAIN = 3'd2,
        MODE_ENTER   = 3'd3,
        MODE_ACT_POS = 3'd4,
        MODE_ACT_POL = 3'd5,
        MODE_FAULT   = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        FAULT_NONE      = 2'd0,
        FAULT_TIMEOUT   = 2'd1,
        FAULT_DEVIATION = 2'd2
    } fault_t;

    typedef logic [TIME_W-1:0] time_t;

    typedef struct packed {
        logic [31:0] time_now;
        logic        all_feedback;
        logic        imu_valid;
        logic        rl_request;
        logic        position_request;
        logic        low_gain_request;
        logic        active_request;
        logic        joints_near_default;
    } item_t;

    typedef struct packed {
        logic [CFG_W-1:0] feedback_timeout;
        logic [CFG_W-1:0] startup_ramp_time;
        logic             imu_optional;
    } cfg_t;

    typedef struct packed {
        mode_t mode;
        time_t wait_start;
        time_t ramp_start;
    } state_t;

    typedef struct packed {
        mode_t  mode_out;
        fault_t fault_code;
        logic   position_control_out;
        logic   fallback_clear;
    } result_t;

endpackage

@@ design/jdsm_ifs.sv @@
interface jdsm_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] time_now;
    logic        all_feedback;
    logic        imu_valid;
    logic        rl_request;
    logic        position_request;
    logic        low_gain_request;
    logic        active_request;
    logic        joints_near_default;

    modport source (
        output valid, time_now, all_feedback, imu_valid, rl_request,
               position_request, low_gain_request, active_request, joints_near_default,
        input  ready
    );
    modport sink (
        input  valid, time_now, all_feedback, imu_valid, rl_request,
               position_request, low_gain_request, active_request, joints_near_default,
        output ready
    );
endinterface

interface jdsm_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode_out;
    logic [1:0] fault_code;
    logic       position_control_out;
    logic       fallback_clear;

    modport source (
        output valid, mode_out, fault_code, position_control_out, fallback_clear,
        input  ready
    );
    modport sink (
        input  valid, mode_out, fault_code, position_control_out, fallback_clear,
        output ready
    );
endinterface

interface jdsm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ design/jdsm_step.sv @@
module jdsm_step (
    input  jdsm_pkg::state_t  state,
    input  jdsm_pkg::item_t   item,
    input  jdsm_pkg::cfg_t    cfg,
    output jdsm_pkg::state_t  state_next,
    output jdsm_pkg::result_t result
);

    always_comb
    begin
        jdsm_pkg::mode_t  m;
        jdsm_pkg::time_t  t;
        jdsm_pkg::time_t  ws;
        jdsm_pkg::time_t  rs;
        jdsm_pkg::time_t  wait_diff;
        jdsm_pkg::time_t  ramp_diff;
        jdsm_pkg::fault_t fault;
        logic             fclear;
        logic             done;
        logic             act;
        logic             rl;
        logic             lowg;

        m         = state.mode;
        ws        = state.wait_start;
        rs        = state.ramp_start;
        t         = jdsm_pkg::TIME_W'(item.time_now);
        fault     = jdsm_pkg::FAULT_NONE;
        fclear    = 1'b0;
        done      = 1'b0;
        act       = item.active_request;
        rl        = item.rl_request;
        lowg      = item.low_gain_request;
        wait_diff = t - ws;

        // Wait for feedback; a wait start of zero means the wait has not begun.
        if (m == jdsm_pkg::MODE_WAIT)
        begin
            if (item.all_feedback)
            begin
                m  = jdsm_pkg::MODE_READY;
                ws = '0;
            end
            else if (cfg.feedback_timeout != '0)
            begin
                if (ws == '0)
                begin
                    ws = t;
                end
                else if (jdsm_pkg::CMP_W'(wait_diff) > jdsm_pkg::CMP_W'(cfg.feedback_timeout))
                begin
                    fault = jdsm_pkg::FAULT_TIMEOUT;
                    m     = jdsm_pkg::MODE_FAULT;
                    done  = 1'b1;
                end
            end
        end

        if (!done)
        begin
            if (m == jdsm_pkg::MODE_READY && lowg)
            begin
                m = jdsm_pkg::MODE_LOWGAIN;
            end
            if (m == jdsm_pkg::MODE_LOWGAIN && !lowg)
            begin
                m = jdsm_pkg::MODE_READY;
            end

            if (m == jdsm_pkg::MODE_READY && act && (item.imu_valid || cfg.imu_optional))
            begin
                if (rl)
                begin
                    m = jdsm_pkg::MODE_ACT_POL;
                end
                else
                begin
                    m  = jdsm_pkg::MODE_ENTER;
                    rs = t;
                end
            end

            // The ramp start may have been set just above, so the difference follows it.
            ramp_diff = t - rs;
            if (m == jdsm_pkg::MODE_ENTER)
            begin
                if (!act)
                begin
                    m = jdsm_pkg::MODE_READY;
                end
                else if (rl)
                begin
                    m = jdsm_pkg::MODE_ACT_POL;
                end
                else if (!item.joints_near_default)
                begin
                    fault = jdsm_pkg::FAULT_DEVIATION;
                    m     = jdsm_pkg::MODE_FAULT;
                end
                else if (jdsm_pkg::CMP_W'(ramp_diff)
                         >= jdsm_pkg::CMP_W'(cfg.startup_ramp_time))
                begin
                    m = jdsm_pkg::MODE_ACT_POS;
                end
            end

            if ((m == jdsm_pkg::MODE_ACT_POS || m == jdsm_pkg::MODE_ACT_POL) && !act)
            begin
                m      = jdsm_pkg::MODE_READY;
                fclear = 1'b1;
            end
            if (m == jdsm_pkg::MODE_ACT_POS && rl)
            begin
                m      = jdsm_pkg::MODE_ACT_POL;
                fclear = 1'b1;
            end
            if (m == jdsm_pkg::MODE_ACT_POL && !rl && act)
            begin
                m      = jdsm_pkg::MODE_ACT_POS;
                fclear = 1'b1;
            end
        end
        else
        begin
            ramp_diff = '0;
        end

        state_next.mode       = m;
        state_next.wait_start = ws;
        state_next.ramp_start = rs;

        result.mode_out             = m;
        result.fault_code           = fault;
        result.position_control_out = item.position_request && !rl;
        result.fallback_clear       = fclear;
    end

endmodule

@@ design/joint_drive_safety_mode_fsm_top.sv @@
// Joint drive safety mode machine.
// Each word on in_ch is one control tick: a time stamp, the feedback and IMU
// flags, the operator requests and the joints-near-default flag. For each
// tick exactly one word leaves on out_ch with the drive mode, the fault code,
// the position request after policy priority and the fallback-clear pulse.
// Registers are written through cfg (0 feedback timeout, 1 ramp time,
// 2 allow missing IMU); cfg is always ready and must only be written while
// the block is idle. Writes to index 3 are dropped.
// A tick is captured in an input register and its transition is evaluated
// from there into the output register, whose result word is valid on out_ch.
// The whole transition is one pass of logic on the mode register, so one
// tick per cycle is sustained while out_ch keeps taking the results.
// When out_ch stalls the result holds and the input register still takes one
// more tick; after that in_ch.ready drops until out_ch drains.
// Reset puts the mode in wait-for-feedback, clears both start times and
// the configuration registers, and empties the pipeline.
`include "joint_drive_safety_mode_fsm_top_macros.svh"

module joint_drive_safety_mode_fsm_top (
    input  logic         clk,
    input  logic         rst_n,
    jdsm_in_if.sink      in_ch,
    jdsm_out_if.source   out_ch,
    jdsm_cfg_if.sink     cfg
);

    jdsm_pkg::cfg_t    cfg_reg;
    jdsm_pkg::state_t  state_reg;
    jdsm_pkg::state_t  state_next;
    jdsm_pkg::item_t   s1_item_reg;
    jdsm_pkg::item_t   in_item;
    jdsm_pkg::result_t out_res_reg;
    jdsm_pkg::result_t step_res;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              advance;
    logic              in_take;

    assign in_item.time_now            = in_ch.time_now;
    assign in_item.all_feedback        = in_ch.all_feedback;
    assign in_item.imu_valid           = in_ch.imu_valid;
    assign in_item.rl_request          = in_ch.rl_request;
    assign in_item.position_request    = in_ch.position_request;
    assign in_item.low_gain_request    = in_ch.low_gain_request;
    assign in_item.active_request      = in_ch.active_request;
    assign in_item.joints_near_default = in_ch.joints_near_default;

    assign advance        = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready    = !s1_valid_reg || advance;
    assign in_take        = in_ch.valid && in_ch.ready;
    assign s1_valid_next  = in_take || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !out_ch.ready);

    assign cfg.ready = 1'b1;

    jdsm_step u_step (
        .state      (state_reg),
        .item       (s1_item_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .result     (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            state_reg.mode   <= jdsm_pkg::MODE_WAIT;
            state_reg.wait_start <= '0;
            state_reg.ramp_start <= '0;
            cfg_reg          <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    jdsm_pkg::CFG_FEEDBACK_TIMEOUT:  cfg_reg.feedback_timeout  <= cfg.data;
                    jdsm_pkg::CFG_STARTUP_RAMP_TIME: cfg_reg.startup_ramp_time <= cfg.data;
                    jdsm_pkg::CFG_IMU_OPTIONAL:      cfg_reg.imu_optional      <= cfg.data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg <= in_item;
        end
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    assign out_ch.valid                = out_valid_reg;
    assign out_ch.mode_out             = out_res_reg.mode_out;
    assign out_ch.fault_code           = out_res_reg.fault_code;
    assign out_ch.position_control_out = out_res_reg.position_control_out;
    assign out_ch.fallback_clear       = out_res_reg.fallback_clear;

    `JDSM_ASSERT(a_fault_absorbing, state_reg.mode == jdsm_pkg::MODE_FAULT |=> state_reg.mode == jdsm_pkg::MODE_FAULT, "damping fault mode was left")
    `JDSM_ASSERT(a_fault_code_mode, out_valid_reg && out_res_reg.fault_code != jdsm_pkg::FAULT_NONE |-> out_res_reg.mode_out == jdsm_pkg::MODE_FAULT, "fault code reported outside fault mode")
    `JDSM_ASSERT(a_wait_start_mode, state_reg.wait_start != '0 |-> state_reg.mode == jdsm_pkg::MODE_WAIT || state_reg.mode == jdsm_pkg::MODE_FAULT, "wait start kept after leaving the wait")
    `JDSM_ASSERT(a_fclear_mode, out_valid_reg && out_res_reg.fallback_clear |-> out_res_reg.mode_out == jdsm_pkg::MODE_READY || out_res_reg.mode_out == jdsm_pkg::MODE_ACT_POS || out_res_reg.mode_out == jdsm_pkg::MODE_ACT_POL, "fallback clear with wrong mode")
    `JDSM_ASSERT(a_state_holds, !advance |=> $stable(state_reg), "mode state changed without a tick")
    `JDSM_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !s1_valid_reg && !out_valid_reg, "pipeline not empty in reset")

endmodule
